// ===== hw/rtl/nonzero_point_window_average_defines.svh =====
`ifndef NONZERO_POINT_WINDOW_AVERAGE_DEFINES_SVH
`define NONZERO_POINT_WINDOW_AVERAGE_DEFINES_SVH

// Assertion helpers. Both sample on aclk and are off while aresetn is low.

// The consequent must hold in the same cycle as the antecedent.
`define NPWA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NPWA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/npwa_pkg.sv =====
package npwa_pkg;

    localparam int PTS       = 12;                  // points in one frame
    localparam int DIST_W    = 16;                  // width of one distance
    localparam int IDX_W     = $clog2(PTS);         // point index width
    localparam int CNT_W     = 12;                  // point count width
    localparam int SUM_W     = 28;                  // distance sum width
    localparam int FRM_W     = 8;                   // frame counter width
    localparam int DIV_STEPS = SUM_W;               // one quotient bit per cycle
    localparam int DCNT_W    = $clog2(DIV_STEPS);   // divide step counter width

    localparam logic [FRM_W-1:0] FRAMES_RESET = FRM_W'(100);

    // Sequencer states.
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_ACCUM = 3'd1;
    localparam logic [ST_W-1:0] ST_CHECK = 3'd2;
    localparam logic [ST_W-1:0] ST_DIV   = 3'd3;
    localparam logic [ST_W-1:0] ST_DONE  = 3'd4;

    typedef logic [PTS-1:0][DIST_W-1:0] frame_t;

endpackage

// ===== hw/rtl/nonzero_point_window_average.sv =====
// Channel   | Direction | tdata                        | tuser      | Meaning
// s_        | in        | dist_0 .. dist_11 (16b each) | -          | one sensor frame
// m_        | out       | average_distance (16b)       | no_points  | one window average
// cfg_      | in        | frames_per_result (8b)       | -          | window length
//
// For each frame the shared adder walks the twelve points one per cycle,
// then the check state compares the frame counter against the window length.
// A frame that closes a non-empty window adds restoring division
// (one quotient bit per cycle) and a step that loads the output register.
// Reset is synchronous on aresetn low; the window length returns to 100 frames.
// A waiting result holds only the frame that closes the next window.

`include "nonzero_point_window_average_defines.svh"

module nonzero_point_window_average
    import npwa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [FRM_W-1:0]     cfg_wdata,   // frames_per_result
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PTS*DIST_W-1:0] s_tdata,    // dist_0 [15:0] up to dist_11 [191:176]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DIST_W-1:0]    m_tdata,     // average_distance [15:0]
    output logic                 m_tuser      // no_points [0]
);

    logic [ST_W-1:0]   state_reg, state_next;
    logic [FRM_W-1:0]  fpr_reg, fpr_next;
    logic [FRM_W-1:0]  fc_reg, fc_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    frame_t            frame_reg, frame_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              np_reg, np_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DIST_W-1:0] m_tdata_reg, m_tdata_next;
    logic              m_tuser_reg, m_tuser_next;

    logic [DIST_W-1:0] dist_cur;
    logic [SUM_W-1:0]  acc_sum;
    logic [FRM_W:0]    fc_inc;
    logic [FRM_W:0]    limit;
    logic              frame_end;
    logic [CNT_W:0]    div_shift;
    logic [CNT_W:0]    div_diff;
    logic              div_ge;
    logic              out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        dist_cur  = frame_reg[0];
        acc_sum   = sum_reg + SUM_W'(dist_cur);
        fc_inc    = {1'b0, fc_reg} + (FRM_W+1)'(1);
        // A register value of zero stands for a window of 256 frames.
        limit     = (fpr_reg == '0) ? {1'b1, {FRM_W{1'b0}}} : {1'b0, fpr_reg};
        frame_end = (fc_inc >= limit);
        div_shift = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        div_diff  = div_shift - {1'b0, count_reg};
        div_ge    = (div_shift >= {1'b0, count_reg});
        out_free  = !m_tvalid_reg || m_tready;

        state_next    = state_reg;
        fpr_next      = cfg_we ? cfg_wdata : fpr_reg;
        fc_next       = fc_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        frame_next    = frame_reg;
        idx_next      = idx_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dcnt_next     = dcnt_reg;
        np_next       = np_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    frame_next = frame_t'(s_tdata);
                    idx_next   = '0;
                    state_next = ST_ACCUM;
                end
            end
            ST_ACCUM: begin
                // The frame shifts down one point per cycle into the adder.
                frame_next[PTS-2:0] = frame_reg[PTS-1:1];
                frame_next[PTS-1]   = '0;
                if (dist_cur != '0) begin
                    sum_next   = acc_sum;
                    count_next = count_reg + CNT_W'(1);
                end
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg == IDX_W'(PTS-1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!frame_end) begin
                    fc_next    = fc_reg + FRM_W'(1);
                    state_next = ST_IDLE;
                end else if (count_reg == '0) begin
                    quo_next   = '0;
                    np_next    = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rem_next   = '0;
                    quo_next   = sum_reg;
                    dcnt_next  = '0;
                    np_next    = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next  = div_ge ? div_diff : div_shift;
                quo_next  = {quo_reg[SUM_W-2:0], div_ge};
                dcnt_next = dcnt_reg + DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(DIV_STEPS-1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = quo_reg[DIST_W-1:0];
                    m_tuser_next  = np_reg;
                    fc_next       = '0;
                    count_next    = '0;
                    sum_next      = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fpr_reg      <= FRAMES_RESET;
            fc_reg       <= '0;
            count_reg    <= '0;
            sum_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fpr_reg      <= fpr_next;
            fc_reg       <= fc_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        frame_reg   <= frame_next;
        idx_reg     <= idx_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dcnt_reg    <= dcnt_next;
        np_reg      <= np_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    `NPWA_ASSERT_NEXT(a_accept_starts_accum, s_tvalid && s_tready, state_reg == ST_ACCUM, "accepted frame did not start accumulation")
    `NPWA_ASSERT_SAME(a_div_nonzero_count, state_reg == ST_DIV, count_reg != '0, "division started with a zero point count")
    `NPWA_ASSERT_SAME(a_div_steps_bound, state_reg == ST_DIV, dcnt_reg <= DCNT_W'(DIV_STEPS-1), "divide step counter ran past the last step")
    `NPWA_ASSERT_NEXT(a_midwindow_returns_idle, state_reg == ST_CHECK && !frame_end, state_reg == ST_IDLE && count_reg == $past(count_reg), "frame inside a window disturbed the totals")
    `NPWA_ASSERT_SAME(a_empty_window_zero, m_tvalid && m_tuser, m_tdata == '0, "empty window result carries a nonzero average")

endmodule
